// File: rtl/core/lctm_pkg.sv
// Shared types and constants of the load-cell trimmed-mean weigher.
package lctm_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 24;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 8;
  localparam int FACTOR_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Bytes per sample, counted 0 .. LAST_BYTE
  localparam logic [2:0] LAST_BYTE = 3'd5;

  // Smallest usable batch size
  localparam logic [COUNT_W-1:0] MIN_COUNT = 8'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FACTOR = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT  = 8'd10;
  localparam logic [SAMPLE_W-1:0] RST_TARE_OFFSET   = 24'd0;
  localparam logic [FACTOR_W-1:0] RST_WEIGHT_FACTOR = 32'h0100_0000;

  // Saturation limits of the Q16.16 result
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TRIM   = 9'b000000010,
    ST_ABS    = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_QSIGN  = 9'b000010000,
    ST_DIFF   = 9'b000100000,
    ST_MUL_LO = 9'b001000000,
    ST_MUL_HI = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic trim;
    logic div_init;
    logic div_step;
    logic q_sign;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic byte_last;
    logic batch_end;
    logic out_busy;
    logic div_done;
  } status_t;

endpackage

// File: rtl/core/lctm_if.sv
// Channel interfaces: input bytes, results and configuration writes.
interface lctm_in_if;
  logic                        valid;
  logic                        ready;
  logic [lctm_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lctm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lctm_pkg::SAMPLE_W-1:0] raw_sample;
  logic signed [lctm_pkg::WEIGHT_W-1:0] weight;
  logic                                 weight_valid;

  modport source (output valid, output raw_sample, output weight, output weight_valid,
                  input ready);
  modport sink   (input valid, input raw_sample, input weight, input weight_valid,
                  output ready);
endinterface

interface lctm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lctm_pkg::CFG_IDX_W-1:0]  index;
  logic [lctm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/load_cell_trimmed_mean_weigher.sv
// Top level of the load-cell trimmed-mean weigher.
//
// Usage:
//   in_if  : one received SPI byte per transfer; six bytes build one 24-bit
//            sample from bits 6, 4, 2, 0 of each byte, most significant first.
//   out_if : one result per sample: raw_sample, and on the sample that closes
//            a batch of sample_count samples, the trimmed-mean weight in
//            Q16.16 with weight_valid set (weight is 0 otherwise).
//   cfg_if : register writes, index 0 sample_count, 1 tare_offset,
//            2 weight_factor; other indexes are ignored. Always ready.
// Sequence:
//   Bytes that do not close a sample are taken whenever the controller is
//   idle. A sample that does not close a batch shows its result the cycle
//   after its sixth byte. A closing sample instead goes through trim, the
//   32-step bit-serial divider, sign, tare, two half-width multiplies and
//   the round/saturate step; no byte is taken during that time.
// Reset (rst_n low, synchronous): registers return to their defaults, the
//   byte position and batch count clear, and no result is pending.
// Stall: a sixth byte waits while the output register is still full;
//   other bytes keep flowing.
module load_cell_trimmed_mean_weigher (
  input  logic        clk,
  input  logic        rst_n,
  lctm_in_if.sink     in_if,
  lctm_out_if.source  out_if,
  lctm_cfg_if.sink    cfg_if
);
  import lctm_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_if.ready = 1'b1;

  lctm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lctm_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_rx_byte       (in_if.rx_byte),
    .cfg_valid        (cfg_if.valid),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_raw_sample   (out_if.raw_sample),
    .out_weight       (out_if.weight),
    .out_weight_valid (out_if.weight_valid)
  );

endmodule

// File: rtl/core/lctm_ctrl.sv
// Sequencer: byte intake, then trim, divide, scale and round at batch end.
module lctm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lctm_pkg::status_t st,
  output lctm_pkg::cmd_t    cmd
);
  import lctm_pkg::*;

  state_t state_r, state_nxt;

  // A closing byte needs the output register free
  assign in_ready = (state_r == ST_IDLE) && !(st.byte_last && st.out_busy);

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.accept   = in_valid && in_ready;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && st.batch_end) state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = ST_QSIGN;
      end
      ST_QSIGN: begin
        cmd.q_sign = 1'b1;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Divider runs its full length before the sign fix-up
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && st.div_done |=> (state_r == ST_QSIGN))
    else $error("divider exit did not reach sign stage");

  // No byte taken while a batch result is being worked out
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input ready outside idle");

  // Batch close always ends in a finish step: trim, load, 32 steps, 4 more
  a_close_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && st.batch_end |=> ##38 (state_r == ST_FIN))
    else $error("batch close sequence broken");

endmodule

// File: rtl/core/lctm_datapath.sv
// Datapath: sample assembly, batch statistics, serial divider, scaling, output register.
module lctm_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lctm_pkg::cmd_t                        cmd,
  output lctm_pkg::status_t                     st,
  input  logic [lctm_pkg::BYTE_W-1:0]           in_rx_byte,
  input  logic                                  cfg_valid,
  input  logic [lctm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lctm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [lctm_pkg::SAMPLE_W-1:0]  out_raw_sample,
  output logic signed [lctm_pkg::WEIGHT_W-1:0]  out_weight,
  output logic                                  out_weight_valid
);
  import lctm_pkg::*;

  // Configuration registers
  logic [COUNT_W-1:0]         sample_count_r;
  logic signed [SAMPLE_W-1:0] tare_offset_r;
  logic signed [FACTOR_W-1:0] weight_factor_r;

  // Sample assembly and batch statistics
  logic [2:0]                 byte_pos_r;
  logic [SAMPLE_W-1:0]        shift_r;
  logic [COUNT_W-1:0]         taken_r;
  logic signed [31:0]         sum_r;
  logic signed [SAMPLE_W-1:0] max_r, min_r;

  // Batch-end arithmetic
  logic signed [31:0]         trim_r;
  logic                       neg_r;
  logic [31:0]                quot_r;
  logic [7:0]                 rem_r;
  logic [7:0]                 divisor_r;
  logic [4:0]                 dcnt_r;
  logic signed [31:0]         qs_r;
  logic signed [32:0]         diff_r;
  logic signed [49:0]         plo_r;
  logic signed [48:0]         phi_r;

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_raw_r;
  logic signed [WEIGHT_W-1:0] out_weight_r;
  logic                       out_wv_r;

  logic [3:0]                 nib;
  logic [SAMPLE_W-1:0]        shift_new;
  logic signed [SAMPLE_W-1:0] s;
  logic [COUNT_W:0]           taken_inc;
  logic [COUNT_W-1:0]         cnt_eff;
  logic                       byte_last;
  logic                       batch_end;
  logic                       first;
  logic [8:0]                 rem_sh;
  logic [8:0]                 rem_sub;
  logic                       ge;
  logic signed [65:0]         rnd;
  logic [57:0]                w;
  logic [WEIGHT_W-1:0]        w_sat;

  // Data bits sit at 6, 4, 2 and 0 of each byte
  assign nib       = {in_rx_byte[6], in_rx_byte[4], in_rx_byte[2], in_rx_byte[0]};
  assign shift_new = {shift_r[SAMPLE_W-5:0], nib};
  assign s         = $signed(shift_new);

  // Batch closes once the samples taken reach the effective count
  assign cnt_eff   = (sample_count_r < MIN_COUNT) ? MIN_COUNT : sample_count_r;
  assign taken_inc = {1'b0, taken_r} + 9'd1;
  assign byte_last = (byte_pos_r == LAST_BYTE);
  assign batch_end = byte_last && (taken_inc >= {1'b0, cnt_eff});
  assign first     = (taken_r == '0);

  // One restoring divide step
  assign rem_sh  = {rem_r, quot_r[31]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  assign ge      = (rem_sh >= {1'b0, divisor_r});

  // Recombine partial products, round half up, floor shift by 8, saturate
  assign rnd = $signed({phi_r[48], phi_r, 16'd0}) + $signed({{16{plo_r[49]}}, plo_r})
             + 66'sd128;
  assign w   = rnd[65:8];
  always_comb begin
    if ((&w[57:31]) || !(|w[57:31])) begin
      w_sat = w[31:0];
    end else if (w[57]) begin
      w_sat = WEIGHT_MIN;
    end else begin
      w_sat = WEIGHT_MAX;
    end
  end

  assign st.byte_last = byte_last;
  assign st.batch_end = batch_end;
  assign st.out_busy  = out_valid_r;
  assign st.div_done  = (dcnt_r == 5'd31);

  // Configuration and intake control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= RST_SAMPLE_COUNT;
      tare_offset_r   <= RST_TARE_OFFSET;
      weight_factor_r <= RST_WEIGHT_FACTOR;
      byte_pos_r      <= '0;
      shift_r         <= '0;
      taken_r         <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT:  sample_count_r  <= cfg_data[COUNT_W-1:0];
          CFG_TARE_OFFSET:   tare_offset_r   <= $signed(cfg_data[SAMPLE_W-1:0]);
          CFG_WEIGHT_FACTOR: weight_factor_r <= $signed(cfg_data[FACTOR_W-1:0]);
          default: ;
        endcase
      end
      if (cmd.accept) begin
        shift_r    <= shift_new;
        byte_pos_r <= byte_last ? 3'd0 : byte_pos_r + 3'd1;
        if (byte_last) begin
          taken_r <= batch_end ? '0 : taken_inc[COUNT_W-1:0];
        end
      end
    end
  end

  // Batch statistics, loaded fresh by the first sample of a batch
  always_ff @(posedge clk) begin
    if (cmd.accept && byte_last) begin
      sum_r <= (first ? 32'sd0 : sum_r) + 32'(s);
      max_r <= (first || (s > max_r)) ? s : max_r;
      min_r <= (first || (s < min_r)) ? s : min_r;
    end
  end

  // Trim, divide, sign, tare, multiply
  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      trim_r <= sum_r - 32'(max_r) - 32'(min_r);
    end
    if (cmd.div_init) begin
      neg_r     <= trim_r[31];
      quot_r    <= trim_r[31] ? 32'(-trim_r) : 32'(trim_r);
      rem_r     <= '0;
      dcnt_r    <= '0;
      divisor_r <= cnt_eff - 8'd2;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? rem_sub[7:0] : rem_sh[7:0];
      quot_r <= {quot_r[30:0], ge};
      dcnt_r <= dcnt_r + 5'd1;
    end
    if (cmd.q_sign) begin
      qs_r <= neg_r ? -$signed(quot_r) : $signed(quot_r);
    end
    if (cmd.diff) begin
      diff_r <= 33'(qs_r) - 33'(tare_offset_r);
    end
    if (cmd.mul_lo) begin
      plo_r <= diff_r * $signed({1'b0, weight_factor_r[15:0]});
    end
    if (cmd.mul_hi) begin
      phi_r <= diff_r * $signed(weight_factor_r[31:16]);
    end
  end

  // Output register: raw sample on each sixth byte, weight at batch end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.accept && byte_last && !batch_end) || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && byte_last) begin
      out_raw_r    <= s;
      out_weight_r <= '0;
      out_wv_r     <= 1'b0;
    end else if (cmd.finish) begin
      out_weight_r <= $signed(w_sat);
      out_wv_r     <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_raw_sample   = out_raw_r;
  assign out_weight       = out_weight_r;
  assign out_weight_valid = out_wv_r;

  // Finish always presents a weight
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && out_wv_r))
    else $error("finish did not load a weight result");

  // Non-closing samples carry a zero weight
  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wv_r) |-> (out_weight_r == '0))
    else $error("weight nonzero on a non-closing sample");

  // Byte position never passes the last byte of a sample
  a_byte_pos: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= LAST_BYTE)
    else $error("byte position out of range");

endmodule
